[src/trhsv_pkg.sv]
// Package for the throttled RGB-to-HSV light command core.
// Holds the item, command and configuration types, outcome codes and divider constants.
// No dependencies; every other file refers to it by scoped names.
package trhsv_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0] MIN_INTERVAL_RST  = 16'd1000;
    localparam logic [15:0] STUCK_TIMEOUT_RST = 16'd5000;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_MIN_INTERVAL  = 1'b0;
    localparam logic REG_STUCK_TIMEOUT = 1'b1;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam int DIV_REM_W = 11;
    localparam int DIV_LO_W  = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WIDE   = 5'd16;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NARROW = 5'd8;

    typedef enum logic [2:0] {
        OUT_THROTTLED = 3'd0,
        OUT_BUSY_SKIP = 3'd1,
        OUT_UNCHANGED = 3'd2,
        OUT_ISSUED    = 3'd3,
        OUT_COMPLETED = 3'd4
    } t_outcome;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_in_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [15:0] hue_value;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic        light_on;
    } t_out_item;

    typedef struct packed {
        t_outcome   outcome;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cmd;

    typedef struct packed {
        logic [15:0] min_interval_ms;
        logic [15:0] stuck_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_LO_W-1:0]  lo;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_LO_W-1:0] quot;
    } t_div_rsp;

endpackage

[src/trhsv_front.sv]
// Front end: accepts requests, applies throttle, busy and unchanged-colour checks.
// Owns the stored time, colour and busy state. Depends on trhsv_pkg.
module trhsv_front #(
    parameter int TIME_BITS = trhsv_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trhsv_pkg::t_cfg     i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  trhsv_pkg::t_in_item i_in_item,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output trhsv_pkg::t_cmd     o_push_cmd
);

    logic [63:0]          w_now_wide;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_accept;
    logic                 w_throttled;
    logic                 w_stuck;
    logic                 w_same;

    logic [TIME_BITS-1:0] r_last_time, n_last_time;
    logic [7:0]           r_last_red, n_last_red;
    logic [7:0]           r_last_green, n_last_green;
    logic [7:0]           r_last_blue, n_last_blue;
    logic                 r_busy, n_busy;

    assign w_now_wide  = {32'b0, i_in_item.now_ms};
    assign w_now       = w_now_wide[TIME_BITS-1:0];
    assign w_elapsed   = w_now - r_last_time;
    assign w_throttled = w_elapsed < TIME_BITS'(i_cfg.min_interval_ms);
    assign w_stuck     = w_elapsed > TIME_BITS'(i_cfg.stuck_timeout_ms);
    assign w_same      = (i_in_item.red == r_last_red) && (i_in_item.green == r_last_green)
                         && (i_in_item.blue == r_last_blue);

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;
    assign w_accept     = i_in_valid && i_push_ready;

    always_comb begin
        n_last_time        = r_last_time;
        n_last_red         = r_last_red;
        n_last_green       = r_last_green;
        n_last_blue        = r_last_blue;
        n_busy             = r_busy;
        o_push_cmd.red     = i_in_item.red;
        o_push_cmd.green   = i_in_item.green;
        o_push_cmd.blue    = i_in_item.blue;
        o_push_cmd.outcome = trhsv_pkg::OUT_THROTTLED;
        if (i_in_item.operation == trhsv_pkg::OP_COMPLETE) begin
            n_busy             = 1'b0;
            o_push_cmd.outcome = trhsv_pkg::OUT_COMPLETED;
        end else if (w_throttled) begin
            o_push_cmd.outcome = trhsv_pkg::OUT_THROTTLED;
        end else if (r_busy && !w_stuck) begin
            o_push_cmd.outcome = trhsv_pkg::OUT_BUSY_SKIP;
        end else begin
            // A stuck request is dropped and the update carries on.
            n_busy = 1'b0;
            if (w_same) begin
                if (w_stuck) begin
                    n_last_time = w_now;
                end
                o_push_cmd.outcome = trhsv_pkg::OUT_UNCHANGED;
            end else begin
                n_last_time        = w_now;
                n_last_red         = i_in_item.red;
                n_last_green       = i_in_item.green;
                n_last_blue        = i_in_item.blue;
                n_busy             = 1'b1;
                o_push_cmd.outcome = trhsv_pkg::OUT_ISSUED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_last_red   <= '0;
            r_last_green <= '0;
            r_last_blue  <= '0;
            r_busy       <= 1'b0;
        end else if (w_accept) begin
            r_last_time  <= n_last_time;
            r_last_red   <= n_last_red;
            r_last_green <= n_last_green;
            r_last_blue  <= n_last_blue;
            r_busy       <= n_busy;
        end
    end

endmodule

[src/trhsv_queue.sv]
// Short command queue between the front end and the conversion back end.
// Register-based circular buffer. Depends on trhsv_pkg.
module trhsv_queue #(
    parameter int DEPTH = trhsv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  trhsv_pkg::t_cmd i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output trhsv_pkg::t_cmd o_pop_cmd
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    trhsv_pkg::t_cmd r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_idx];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_idx <= (r_wr_idx == IDX_W'(DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            end
            if (w_pop) begin
                r_rd_idx <= (r_rd_idx == IDX_W'(DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_idx] <= i_push_cmd;
        end
    end

endmodule

[src/trhsv_div.sv]
// Shared restoring divider, one quotient bit per cycle, up to 16 bits.
// The caller preloads the partial remainder so only the quotient bits it needs are run.
// Depends on trhsv_pkg.
module trhsv_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trhsv_pkg::t_div_req i_req,
    output trhsv_pkg::t_div_rsp o_rsp
);

    localparam int RW = trhsv_pkg::DIV_REM_W;
    localparam int LW = trhsv_pkg::DIV_LO_W;
    localparam int CW = trhsv_pkg::DIV_CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [LW-1:0] r_lo;
    logic [RW-1:0] r_divisor;
    logic [LW-1:0] r_quot;

    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;
    logic          w_fit;
    logic [RW-1:0] w_rem_next;

    assign w_trial    = {r_rem, r_lo[LW-1]};
    assign w_diff     = w_trial - {1'b0, r_divisor};
    assign w_fit      = w_trial >= {1'b0, r_divisor};
    assign w_rem_next = w_fit ? w_diff[RW-1:0] : w_trial[RW-1:0];

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_req.rem;
            r_lo      <= i_req.lo;
            r_divisor <= i_req.divisor;
            r_quot    <= '0;
        end else if (r_busy) begin
            r_rem  <= w_rem_next;
            r_lo   <= {r_lo[LW-2:0], 1'b0};
            r_quot <= {r_quot[LW-2:0], w_fit};
        end
    end

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while a division was running");

endmodule

[src/trhsv_back.sv]
// Back end: turns queued commands into result items, running hue and saturation
// through the shared divider. Depends on trhsv_pkg.
module trhsv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pop_valid,
    output logic                 o_pop_ready,
    input  trhsv_pkg::t_cmd      i_pop_cmd,
    output trhsv_pkg::t_div_req  o_div_req,
    input  trhsv_pkg::t_div_rsp  i_div_rsp,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output trhsv_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {S_IDLE, S_HUE, S_SAT, S_DONE} t_state;

    t_state               r_state;
    logic                 r_launch;
    logic                 r_out_valid;
    trhsv_pkg::t_out_item r_out_item;
    logic [26:0]          r_hue_num;
    logic [15:0]          r_sat_num;
    logic [10:0]          r_d6;
    logic [7:0]           r_mx;
    logic [7:0]           r_bri;
    logic [15:0]          r_hue;

    logic [7:0]  w_mx;
    logic [7:0]  w_mn;
    logic [7:0]  w_d;
    logic [10:0] w_d6;
    logic [10:0] w_h;
    logic        w_out_free;
    logic        w_pop;
    logic [7:0]  w_bri;

    // Largest and smallest component; on a tie red wins over green, green over blue.
    always_comb begin
        w_mx = i_pop_cmd.red;
        w_mn = i_pop_cmd.red;
        if (i_pop_cmd.green > w_mx) w_mx = i_pop_cmd.green;
        if (i_pop_cmd.blue > w_mx) w_mx = i_pop_cmd.blue;
        if (i_pop_cmd.green < w_mn) w_mn = i_pop_cmd.green;
        if (i_pop_cmd.blue < w_mn) w_mn = i_pop_cmd.blue;
    end

    assign w_d  = w_mx - w_mn;
    assign w_d6 = 11'({w_d, 2'b00}) + 11'({w_d, 1'b0});

    // Hue numerator in sixths of a turn, scaled by d; below 6*d whenever d is nonzero.
    always_comb begin
        if (w_mx == i_pop_cmd.red) begin
            if (i_pop_cmd.green >= i_pop_cmd.blue) begin
                w_h = 11'(i_pop_cmd.green) - 11'(i_pop_cmd.blue);
            end else begin
                w_h = w_d6 - (11'(i_pop_cmd.blue) - 11'(i_pop_cmd.green));
            end
        end else if (w_mx == i_pop_cmd.green) begin
            w_h = 11'(i_pop_cmd.blue) + 11'({w_d, 1'b0}) - 11'(i_pop_cmd.red);
        end else begin
            w_h = 11'(i_pop_cmd.red) + 11'({w_d, 2'b00}) - 11'(i_pop_cmd.green);
        end
    end

    // floor(mx * 254 / 255) equals mx - 1 for every nonzero mx.
    assign w_bri = w_mx - {7'b0, (w_mx != 8'd0)};

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_pop_ready = (r_state == S_IDLE) && w_out_free;
    assign w_pop       = i_pop_valid && o_pop_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Every quotient here is known to fit its field, so the upper dividend bits
    // go straight into the partial remainder and only the needed bits are run.
    always_comb begin
        o_div_req.start = r_launch;
        case (r_state)
            S_HUE: begin
                o_div_req.rem     = r_hue_num[26:16];
                o_div_req.lo      = r_hue_num[15:0];
                o_div_req.divisor = r_d6;
                o_div_req.steps   = trhsv_pkg::DIV_STEPS_WIDE;
            end
            default: begin
                o_div_req.rem     = 11'(r_sat_num[15:8]);
                o_div_req.lo      = {r_sat_num[7:0], 8'b0};
                o_div_req.divisor = 11'(r_mx);
                o_div_req.steps   = trhsv_pkg::DIV_STEPS_NARROW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        if ((i_pop_cmd.outcome == trhsv_pkg::OUT_ISSUED) && (w_d != 8'd0)) begin
                            // Products by 65535 and 254 are formed with shifts.
                            r_hue_num <= {w_h, 16'b0} - 27'(w_h);
                            r_sat_num <= {w_d, 8'b0} - 16'({w_d, 1'b0});
                            r_d6      <= w_d6;
                            r_mx      <= w_mx;
                            r_bri     <= w_bri;
                            r_launch  <= 1'b1;
                            r_state   <= S_HUE;
                        end else begin
                            // Non-issued or gray/black commands get no hue or saturation.
                            r_out_valid           <= 1'b1;
                            r_out_item.outcome    <= i_pop_cmd.outcome;
                            r_out_item.hue_value  <= '0;
                            r_out_item.saturation <= '0;
                            if (i_pop_cmd.outcome == trhsv_pkg::OUT_ISSUED) begin
                                r_out_item.brightness <= w_bri;
                                r_out_item.light_on   <= w_bri != 8'd0;
                            end else begin
                                r_out_item.brightness <= '0;
                                r_out_item.light_on   <= 1'b0;
                            end
                        end
                    end
                end
                S_HUE: begin
                    if (i_div_rsp.done) begin
                        r_hue    <= i_div_rsp.quot;
                        r_launch <= 1'b1;
                        r_state  <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (i_div_rsp.done) begin
                        r_out_item.outcome    <= trhsv_pkg::OUT_ISSUED;
                        r_out_item.hue_value  <= r_hue;
                        r_out_item.saturation <= i_div_rsp.quot[7:0];
                        r_out_item.brightness <= r_bri;
                        r_out_item.light_on   <= r_bri != 8'd0;
                        r_state               <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_skip_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_item.outcome != trhsv_pkg::OUT_ISSUED) |->
        (r_out_item.hue_value == '0) && (r_out_item.saturation == '0)
        && (r_out_item.brightness == '0) && !r_out_item.light_on)
        else $error("skip or completion result carries nonzero color fields");

    a_light_on_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_item.light_on == (r_out_item.brightness != 8'd0))
        else $error("light_on disagrees with brightness");

    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_HUE) || (r_state == S_SAT))
        else $error("divider finished while no division was pending");

endmodule

[src/throttled_rgb_to_hsv_light_command_core.sv]
// Throttled RGB-to-HSV light command core: APB registers, front end, queue, back end.
// Completion, skip, gray and black results pass from the queue to the output register;
// an issued colored command runs hue, then saturation, through the shared divider, which
// yields one quotient bit a cycle over 24 bits; the back end takes no new command meanwhile.
// Other results come 1 per cycle while the output is not stalled.
// Reset (synchronous, active low) clears stored time, color and busy and the queue.
module throttled_rgb_to_hsv_light_command_core #(
    parameter int TIME_BITS   = trhsv_pkg::TIME_BITS_DEF,
    parameter int QUEUE_DEPTH = trhsv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  trhsv_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output trhsv_pkg::t_out_item                o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [trhsv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [trhsv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [trhsv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic [15:0]         r_min_interval;
    logic [15:0]         r_stuck_timeout;
    logic                w_cfg_wr;
    logic                w_reg_idx;
    trhsv_pkg::t_cfg     w_cfg;

    logic                w_push_valid;
    logic                w_push_ready;
    trhsv_pkg::t_cmd     w_push_cmd;
    logic                w_pop_valid;
    logic                w_pop_ready;
    trhsv_pkg::t_cmd     w_pop_cmd;
    trhsv_pkg::t_div_req w_div_req;
    trhsv_pkg::t_div_rsp w_div_rsp;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[2];

    always_comb begin
        unique case (w_reg_idx)
            trhsv_pkg::REG_MIN_INTERVAL:  prdata = trhsv_pkg::APB_DATA_W'(r_min_interval);
            trhsv_pkg::REG_STUCK_TIMEOUT: prdata = trhsv_pkg::APB_DATA_W'(r_stuck_timeout);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval  <= trhsv_pkg::MIN_INTERVAL_RST;
            r_stuck_timeout <= trhsv_pkg::STUCK_TIMEOUT_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                trhsv_pkg::REG_MIN_INTERVAL:  r_min_interval  <= pwdata[15:0];
                trhsv_pkg::REG_STUCK_TIMEOUT: r_stuck_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.min_interval_ms  = r_min_interval;
    assign w_cfg.stuck_timeout_ms = r_stuck_timeout;

    trhsv_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    trhsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    trhsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    trhsv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_cmd   (w_pop_cmd),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
